[hw/rtl/bavg_pkg.sv]
// Shared types and constants for the block average downscaler.
// Register indexes, field widths, reset values and the sequencer state type.
// No dependencies.
package bavg_pkg;

   localparam int PIX_W      = 8;
   localparam int FACTOR_W   = 5;
   localparam int DIM_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_FACTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 2'd2;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd2;
   localparam logic [DIM_W-1:0]    WIDTH_RESET  = 11'd1024;
   localparam logic [DIM_W-1:0]    HEIGHT_RESET = 11'd1024;

   typedef logic [PIX_W-1:0] chan_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_UPD  = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

endpackage

[hw/rtl/block_average_downscaler.sv]
// Block average downscaler top level: column-sum memory, position counters,
// restoring divider and output register. Depends on bavg_pkg.
//
// Shrinks a raster RGB stream by an integer factor F, emitting the truncated
// mean of each full FxF block on the beat that carries its bottom-right pixel.
// Per-column partial sums live in a single synchronous memory that is read
// on the accept edge and written back in the following cycle when the pixel
// lies in a full block. A pixel that completes a block also runs the
// restoring divider, one per channel, one quotient bit per cycle over the sum
// width (8 + 2*clog2(MAX_FACTOR) bits, 16 by default), and then loads the
// output register once rsp_stall does not hold it. A write to any of the
// three registers restarts the frame position. The sum memory needs no
// clearing after reset.
module block_average_downscaler
   import bavg_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_FACTOR = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_red_in,
   input  logic [PIX_W-1:0]      req_green_in,
   input  logic [PIX_W-1:0]      req_blue_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_red_out,
   output logic [PIX_W-1:0]      rsp_green_out,
   output logic [PIX_W-1:0]      rsp_blue_out,
   output logic                  rsp_frame_done,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int XW  = $clog2(MAX_WIDTH + MAX_FACTOR + 1);
   localparam int YW  = $clog2(MAX_HEIGHT + MAX_FACTOR + 1);
   localparam int FW  = $clog2(MAX_FACTOR + 1);
   localparam int IW  = $clog2(MAX_FACTOR);
   localparam int AW  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
   localparam int SW  = PIX_W + 2 * $clog2(MAX_FACTOR);
   localparam int DCW = $clog2(SW);

   // configuration
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic                cfg_hit;

   logic [FW-1:0] f_cl;
   logic [WW-1:0] w_cl;
   logic [HW-1:0] h_cl;

   // position
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [IW-1:0] cib_ff, cib_in;
   logic [IW-1:0] rib_ff, rib_in;
   logic [CW-1:0] ocol_ff, ocol_in;

   logic col_fit, row_fit, blk_first, blk_last, frm_last;
   logic col_end, row_end, cib_end, rib_end;

   // sequencer
   state_type state_ff, state_in;
   logic      accept;

   // captured beat
   chan_type      pix_ff [3];
   logic [CW-1:0] addr_ff;
   logic          first_ff, wr_ff, emit_ff, done_ff;

   // column-sum memory
   logic [3*SW-1:0] sum_mem [MAX_WIDTH];
   logic [3*SW-1:0] rd_data_ff;
   logic [3*SW-1:0] wr_data;
   logic            mem_we;
   logic [SW-1:0]   sum_new [3];

   // divider
   logic [AW-1:0]  area_ff;
   logic [SW-1:0]  dq_ff [3];
   logic [SW-1:0]  dq_in [3];
   logic [AW-1:0]  drem_ff [3];
   logic [AW-1:0]  drem_in [3];
   logic [DCW-1:0] dcnt_ff;
   logic [AW:0]    dtrial [3];

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_load;
   chan_type rsp_pix_ff [3];
   logic     rsp_done_ff;

   // ------------------------------------------------------------------
   always_comb begin
      if (factor_ff == '0) begin
         f_cl = FW'(1);
      end else if (32'(factor_ff) > 32'(MAX_FACTOR)) begin
         f_cl = FW'(MAX_FACTOR);
      end else begin
         f_cl = FW'(factor_ff);
      end
      if (width_ff == '0) begin
         w_cl = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_cl = WW'(MAX_WIDTH);
      end else begin
         w_cl = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_cl = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_cl = HW'(MAX_HEIGHT);
      end else begin
         h_cl = HW'(height_ff);
      end
   end

   assign cfg_hit = csr_write_en && (csr_index == CSR_SHRINK_FACTOR ||
                                     csr_index == CSR_FRAME_WIDTH ||
                                     csr_index == CSR_FRAME_HEIGHT);

   always_comb begin
      factor_in = factor_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SHRINK_FACTOR: factor_in = csr_write_data[FACTOR_W-1:0];
            CSR_FRAME_WIDTH:   width_in  = csr_write_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT:  height_in = csr_write_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);

   // block fits when its start column (row) plus F stays within the frame width (height)
   assign col_fit   = (XW'(col_ff) - XW'(cib_ff) + XW'(f_cl)) <= XW'(w_cl);
   assign row_fit   = (YW'(row_ff) - YW'(rib_ff) + YW'(f_cl)) <= YW'(h_cl);
   assign cib_end   = (FW'(cib_ff) + FW'(1)) >= f_cl;
   assign rib_end   = (FW'(rib_ff) + FW'(1)) >= f_cl;
   assign col_end   = (XW'(col_ff) + XW'(1)) >= XW'(w_cl);
   assign row_end   = (YW'(row_ff) + YW'(1)) >= YW'(h_cl);
   assign blk_first = (cib_ff == '0) && (rib_ff == '0);
   assign blk_last  = cib_end && rib_end;
   assign frm_last  = ((XW'(col_ff) + XW'(f_cl)) >= XW'(w_cl)) &&
                      ((YW'(row_ff) + YW'(f_cl)) >= YW'(h_cl));

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      cib_in  = cib_ff;
      rib_in  = rib_ff;
      ocol_in = ocol_ff;
      if (cfg_hit) begin
         col_in  = '0;
         row_in  = '0;
         cib_in  = '0;
         rib_in  = '0;
         ocol_in = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in  = '0;
            cib_in  = '0;
            ocol_in = '0;
            if (row_end) begin
               row_in = '0;
               rib_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
               rib_in = rib_end ? '0 : rib_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
            if (cib_end) begin
               cib_in  = '0;
               ocol_in = ocol_ff + 1'b1;
            end else begin
               cib_in = cib_ff + 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_new[c] = first_ff ? SW'(pix_ff[c]) :
                      rd_data_ff[c*SW +: SW] + SW'(pix_ff[c]);
         wr_data[c*SW +: SW] = sum_new[c];
      end
   end

   assign mem_we = (state_ff == S_UPD) && wr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= sum_mem[ocol_ff];
      end
   end

   // ------------------------------------------------------------------
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dtrial[c] = {drem_ff[c], dq_ff[c][SW-1]};
         if (dtrial[c] >= {1'b0, area_ff}) begin
            drem_in[c] = AW'(dtrial[c] - {1'b0, area_ff});
            dq_in[c]   = {dq_ff[c][SW-2:0], 1'b1};
         end else begin
            drem_in[c] = dtrial[c][AW-1:0];
            dq_in[c]   = {dq_ff[c][SW-2:0], 1'b0};
         end
      end
   end

   assign rsp_load     = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_UPD;
         end
         S_UPD: begin
            state_in = emit_ff ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            if (dcnt_ff == '0) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff    <= FACTOR_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         cib_ff       <= '0;
         rib_ff       <= '0;
         ocol_ff      <= '0;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         factor_ff    <= factor_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cib_ff       <= cib_in;
         rib_ff       <= rib_in;
         ocol_ff      <= ocol_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff[0] <= req_red_in;
         pix_ff[1] <= req_green_in;
         pix_ff[2] <= req_blue_in;
         addr_ff   <= ocol_ff;
         first_ff  <= blk_first;
         wr_ff     <= col_fit && row_fit;
         emit_ff   <= col_fit && row_fit && blk_last;
         done_ff   <= frm_last;
      end
      if (state_ff == S_UPD) begin
         area_ff <= AW'(f_cl) * AW'(f_cl);
         dcnt_ff <= DCW'(SW - 1);
         for (int c = 0; c < 3; c++) begin
            dq_ff[c]   <= sum_new[c];
            drem_ff[c] <= '0;
         end
      end else if (state_ff == S_DIV) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         for (int c = 0; c < 3; c++) begin
            dq_ff[c]   <= dq_in[c];
            drem_ff[c] <= drem_in[c];
         end
      end
      if (rsp_load) begin
         for (int c = 0; c < 3; c++) begin
            rsp_pix_ff[c] <= dq_ff[c][PIX_W-1:0];
         end
         rsp_done_ff <= done_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_pix_ff[0];
   assign rsp_green_out  = rsp_pix_ff[1];
   assign rsp_blue_out   = rsp_pix_ff[2];
   assign rsp_frame_done = rsp_done_ff;

   // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   a_ocol_le_col: assert property (@(posedge clock) disable iff (reset)
      ocol_ff <= col_ff)
      else $error("output column ahead of input column");

   a_cib_in_block: assert property (@(posedge clock) disable iff (reset)
      FW'(cib_ff) < f_cl && FW'(rib_ff) < f_cl)
      else $error("in-block position outside the block");

   a_accept_to_upd: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_UPD)
      else $error("accepted beat not followed by sum update");

   a_div_to_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && dcnt_ff == '0) |=> state_ff == S_OUT)
      else $error("divider did not finish on its last step");

   a_load_only_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff) == S_OUT)
      else $error("result loaded outside the output state");
`endif

endmodule
